// File: design/bounded_deque_with_search_top_assert.svh
// ---------------------------------------------------------------------------
// bounded deque assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define BDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: design/bdq_pkg.sv
// ---------------------------------------------------------------------------
// bdq_pkg
// shared types and constants of the bounded deque with search
// ---------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int ST_W          = 2;
   localparam int REQ_W         = ((OP_W + DATA_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK    = 3'd0,
      OP_PUSH_FRONT   = 3'd1,
      OP_REMOVE_BACK  = 3'd2,
      OP_REMOVE_FRONT = 3'd3,
      OP_FIND         = 3'd4
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic exec;
      logic fetch;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_fetch;
      logic is_find;
      logic scan_end;
      logic out_free;
   } stat_type;

endpackage

// File: design/bdq_ram.sv
// ---------------------------------------------------------------------------
// bdq_ram
// generic ram, one write port and one read port with registered read data
// ---------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bdq_ctrl.sv
// ---------------------------------------------------------------------------
// bdq_ctrl
// sequencer: accept, execute, optional fetch or scan, then hand off result
// ---------------------------------------------------------------------------
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bdq_pkg::stat_type stat,
   output bdq_pkg::cmd_type  cmd
);

   import bdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.need_fetch) state_in = S_FETCH;
            else if (stat.is_find) state_in = S_SCAN;
            else state_in = S_DONE;
         end
         S_FETCH: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (stat.scan_end) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_DONE: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/bdq_dpath.sv
// ---------------------------------------------------------------------------
// bdq_dpath
// ring pointers, cached end values, search pipeline and result register
// ---------------------------------------------------------------------------
`include "bounded_deque_with_search_top_assert.svh"

module bdq_dpath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int RSP_W = ((2 * bdq_pkg::DATA_W + CW + 2 + bdq_pkg::ST_W + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bdq_pkg::cmd_type         cmd,
   output bdq_pkg::stat_type        stat,
   input  logic [bdq_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata
);

   import bdq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // base + off, both below DEPTH, folded back into the ring
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
      return s[AW-1:0];
   endfunction

   opcode_type        op_ff, op_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] front_val_ff, front_val_in;
   logic [DATA_W-1:0] back_val_ff, back_val_in;
   logic              found_ff, found_in;
   status_type        status_ff, status_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              cmp_pend_ff, cmp_pend_in;
   logic              load_front_ff, load_front_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              full;
   logic              empty;
   logic              fetch_need;
   logic              hit;
   logic              issue;
   logic              out_free;
   logic [AW-1:0]     front_dec;
   logic [DATA_W-1:0] out_front;
   logic [DATA_W-1:0] out_back;

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign front_dec  = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign fetch_need = ((op_ff == OP_REMOVE_BACK) || (op_ff == OP_REMOVE_FRONT)) &&
                       (count_ff >= CW'(2));
   // compare follows the read in the next cycle, on the registered read data
   assign hit        = cmp_pend_ff && (rd_data == val_ff);
   assign issue      = cmd.scan && !hit && (scan_ff < count_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign stat.need_fetch = fetch_need;
   assign stat.is_find    = (op_ff == OP_FIND);
   assign stat.scan_end   = hit || ((scan_ff >= count_ff) && !cmp_pend_ff);
   assign stat.out_free   = out_free;

   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      front_val_in  = front_val_ff;
      back_val_in   = back_val_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      scan_in       = scan_ff;
      cmp_pend_in   = cmp_pend_ff;
      load_front_in = load_front_ff;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;

      if (cmd.start) begin
         op_in  = opcode_type'(req_tdata[OP_W-1:0]);
         val_in = req_tdata[OP_W +: DATA_W];
      end

      if (cmd.exec) begin
         found_in    = 1'b0;
         status_in   = ST_OK;
         scan_in     = '0;
         cmp_pend_in = 1'b0;
         case (op_ff)
            OP_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = wrap_add(front_ff, count_ff);
                  count_in    = count_ff + CW'(1);
                  back_val_in = val_ff;
                  if (empty) front_val_in = val_ff;
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en        = 1'b1;
                  wr_addr      = front_dec;
                  front_in     = front_dec;
                  count_in     = count_ff + CW'(1);
                  front_val_in = val_ff;
                  if (empty) back_val_in = val_ff;
               end
            end
            OP_REMOVE_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in      = count_ff - CW'(1);
                  rd_en         = fetch_need;
                  rd_addr       = wrap_add(front_ff, count_ff - CW'(2));
                  load_front_in = 1'b0;
               end
            end
            OP_REMOVE_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  front_in      = wrap_add(front_ff, CW'(1));
                  count_in      = count_ff - CW'(1);
                  rd_en         = fetch_need;
                  rd_addr       = wrap_add(front_ff, CW'(1));
                  load_front_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.fetch) begin
         if (load_front_ff) front_val_in = rd_data;
         else back_val_in = rd_data;
      end

      if (cmd.scan) begin
         rd_en       = issue;
         rd_addr     = wrap_add(front_ff, scan_ff);
         cmp_pend_in = issue;
         if (issue) scan_in = scan_ff + CW'(1);
         if (hit) found_in = 1'b1;
      end
   end

   assign out_front   = empty ? '0 : front_val_ff;
   assign out_back    = empty ? '0 : back_val_ff;
   assign rsp_data_in = RSP_W'({status_ff, found_ff, empty, count_ff, out_back, out_front});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cmp_pend_ff  <= cmp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      front_val_ff  <= front_val_in;
      back_val_ff   <= back_val_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      load_front_ff <= load_front_in;
      if (cmd.emit) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BDQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "fill count above depth")
   `BDQ_ASSERT_IMPL(a_scan_bound, clock, reset, 1'b1, scan_ff <= count_ff, "scan index past fill count")
   `BDQ_ASSERT_NEXT(a_push_full, clock, reset, cmd.exec && full && ((op_ff == OP_PUSH_BACK) || (op_ff == OP_PUSH_FRONT)), (status_ff == ST_FULL) && $stable(count_ff) && $stable(front_ff), "push on full deque changed state")
   `BDQ_ASSERT_NEXT(a_remove_empty, clock, reset, cmd.exec && empty && ((op_ff == OP_REMOVE_BACK) || (op_ff == OP_REMOVE_FRONT)), (status_ff == ST_EMPTY) && $stable(count_ff) && $stable(front_ff), "remove on empty deque changed state")

endmodule

// File: design/bounded_deque_with_search_top.sv
// ---------------------------------------------------------------------------
// bounded_deque_with_search_top
// bounded double-ended queue of signed 32-bit values with a linear search
// ---------------------------------------------------------------------------
// usage:
//   req channel carries one command per transfer: opcode (push back, push
//   front, remove back, remove front, find) and a 32-bit value. every command
//   gives exactly one rsp transfer with the front and back values, count,
//   empty flag, found flag and status (ok, dropped on full, remove on empty).
//   one command is in flight at a time; req_tready is high while the
//   sequencer waits for the next command, also while a result still sits in
//   the output register.
//   after a request transfer the sequencer runs an execute step. a remove
//   that leaves the deque non-empty adds a fetch step that reloads the new
//   end value from the ring memory; pushes, removes that empty the deque or
//   hit an empty deque, and unused opcodes add none. a find adds a scan that
//   stops on the first match or after the last entry, one entry per cycle
//   through the memory read port, before the result is loaded for hand-off.
//   a new command is taken the cycle after the result is loaded.
//   reset empties the deque at once; no clearing pass is needed.
//   when the receiver stalls, the result holds in the output register, one
//   more command can be taken and run, and it waits before hand-off.
// ---------------------------------------------------------------------------
module bounded_deque_with_search_top #(
   parameter int DEPTH  = bdq_pkg::DEPTH_DEFAULT,
   localparam int CW    = $clog2(DEPTH + 1),
   localparam int RSP_W = ((2 * bdq_pkg::DATA_W + CW + 2 + bdq_pkg::ST_W + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // opcode [2:0], value [34:3], zero fill above
   input  logic [bdq_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // front_value, back_value, count, is_empty, found, status, zero fill above
   output logic [RSP_W-1:0]          rsp_tdata
);

   import bdq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
